// ===== design/bia_pkg.sv =====
// Shared types, constants and helpers for the bitmap ID allocator.
// Used by bia_ctrl, bia_datapath and bitmap_id_allocator_core; no dependencies.
package bia_pkg;

  // Geometry
  localparam int WORD_BITS = 32;
  localparam int MAP_WORDS = 32;
  localparam int WADDR_W   = 5;   // word address within the map
  localparam int BIT_W     = 5;   // bit position within a word
  localparam int WCNT_W    = 6;   // word count, 0..MAP_WORDS
  localparam int IDX_W     = 10;  // entry index
  localparam int HINT_W    = 11;  // next-fit hint, 0..1024
  localparam int CAP_W     = 11;  // capacity register width
  localparam int CMD_W     = 3;
  localparam int STATUS_W  = 2;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_ALLOC   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_RELEASE = 3'd1;
  localparam logic [CMD_W-1:0] CMD_SET     = 3'd2;
  localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_TEST    = 3'd4;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

  // Controller to datapath commands
  typedef struct packed {
    logic load;          // latch item, compute scan start
    logic rd_start;      // read first word (scan start or index word)
    logic rd_next;       // advance scan to next word and read it
    logic commit_alloc;  // mark found bit, report granted index
    logic commit_single; // release/set/clear/test on one bit
    logic report_full;   // report no free entry
    logic report_plain;  // unknown command, report ok with zeros
  } ctl_t;

  // Datapath to controller status
  typedef struct packed {
    logic is_alloc;
    logic is_single;
    logic no_words;
    logic hit;
    logic last_step;
  } sts_t;

  // Position of the lowest set bit of a word (0 when none)
  function automatic logic [BIT_W-1:0] lowest_set(input logic [WORD_BITS-1:0] v);
    logic [BIT_W-1:0] pos;
    pos = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (v[i]) begin
        pos = BIT_W'(i);
      end
    end
    return pos;
  endfunction

endpackage

// ===== design/bia_ctrl.sv =====
// Sequencer for the bitmap ID allocator: accepts items and steps the datapath.
// Depends on bia_pkg (ctl_t, sts_t).
module bia_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  bia_pkg::sts_t sts,
  output bia_pkg::ctl_t ctl,
  output logic          busy
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_FETCH,
    S_SCAN,
    S_SINGLE
  } state_t;

  state_t state;
  state_t state_next;

  // Next state and datapath commands
  always_comb begin
    state_next = state;
    ctl        = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          ctl.load   = 1'b1;
          state_next = S_FETCH;
        end
      end
      S_FETCH: begin
        if (sts.is_alloc) begin
          if (sts.no_words) begin
            ctl.report_full = 1'b1;
            state_next      = S_IDLE;
          end else begin
            ctl.rd_start = 1'b1;
            state_next   = S_SCAN;
          end
        end else if (sts.is_single) begin
          ctl.rd_start = 1'b1;
          state_next   = S_SINGLE;
        end else begin
          ctl.report_plain = 1'b1;
          state_next       = S_IDLE;
        end
      end
      S_SCAN: begin
        if (sts.hit) begin
          ctl.commit_alloc = 1'b1;
          state_next       = S_IDLE;
        end else if (sts.last_step) begin
          ctl.report_full = 1'b1;
          state_next      = S_IDLE;
        end else begin
          ctl.rd_next = 1'b1;
        end
      end
      S_SINGLE: begin
        ctl.commit_single = 1'b1;
        state_next        = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State and busy flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
    end else begin
      state <= state_next;
      busy  <= (state_next != S_IDLE);
    end
  end

endmodule

// ===== design/bia_datapath.sv =====
// Datapath of the bitmap ID allocator: used-map memory, hint, scan pointer, results.
// Depends on bia_pkg (constants, ctl_t, sts_t, lowest_set).
module bia_datapath (
  input  logic                           clk,
  input  logic                           rst,
  input  bia_pkg::ctl_t                  ctl,
  output bia_pkg::sts_t                  sts,
  input  logic [bia_pkg::CMD_W-1:0]      cmd,
  input  logic [bia_pkg::IDX_W-1:0]      entry_index,
  input  logic                           cfg_write,
  input  logic [bia_pkg::CAP_W-1:0]      cfg_data,
  output logic                           done,
  output logic [bia_pkg::STATUS_W-1:0]   status,
  output logic [bia_pkg::IDX_W-1:0]      granted_index,
  output logic                           bit_value
);

  // Used-map memory; a word never written since reset/config reads as zero
  logic [bia_pkg::WORD_BITS-1:0] mem [bia_pkg::MAP_WORDS];
  logic [bia_pkg::MAP_WORDS-1:0] word_valid;
  logic [bia_pkg::WORD_BITS-1:0] rd_q;
  logic                          rd_valid_q;

  logic [bia_pkg::WCNT_W-1:0]  cap_words;
  logic [bia_pkg::HINT_W-1:0]  hint;
  logic [bia_pkg::CMD_W-1:0]   cmd_q;
  logic [bia_pkg::IDX_W-1:0]   idx_q;
  logic [bia_pkg::WADDR_W-1:0] scan_word;
  logic [bia_pkg::BIT_W-1:0]   start_off;
  logic [bia_pkg::WCNT_W-1:0]  step_cnt;

  logic [bia_pkg::CAP_W-1:0]     cap;
  logic [bia_pkg::HINT_W-1:0]    scan_start;
  logic [bia_pkg::WADDR_W-1:0]   next_word;
  logic [bia_pkg::WORD_BITS-1:0] cur_word;
  logic [bia_pkg::WORD_BITS-1:0] lo_mask;
  logic [bia_pkg::WORD_BITS-1:0] scan_mask;
  logic [bia_pkg::WORD_BITS-1:0] free_bits;
  logic [bia_pkg::BIT_W-1:0]     free_pos;
  logic [bia_pkg::IDX_W-1:0]     alloc_idx;
  logic [bia_pkg::WORD_BITS-1:0] idx_bit;
  logic                          in_range;
  logic                          single_wr;
  logic [bia_pkg::WORD_BITS-1:0] single_word;
  logic                          rd_en;
  logic [bia_pkg::WADDR_W-1:0]   rd_addr;
  logic                          wr_en;
  logic [bia_pkg::WADDR_W-1:0]   wr_addr;
  logic [bia_pkg::WORD_BITS-1:0] wr_data;
  logic [bia_pkg::WADDR_W+1:0]   cfg_words;

  // Capacity in entries and scan start (hint, or zero when past capacity)
  assign cap        = {cap_words, {bia_pkg::BIT_W{1'b0}}};
  assign scan_start = (hint < cap) ? hint : '0;
  assign next_word  = (({1'b0, scan_word} + 6'd1) == cap_words) ? '0 : scan_word + 5'd1;

  // Word under test, masked to the part of the scan it belongs to
  assign cur_word  = rd_valid_q ? rd_q : '0;
  assign lo_mask   = {bia_pkg::WORD_BITS{1'b1}} << start_off;
  always_comb begin
    if (step_cnt == '0) begin
      scan_mask = lo_mask;
    end else if (step_cnt == cap_words) begin
      scan_mask = ~lo_mask;
    end else begin
      scan_mask = '1;
    end
  end
  assign free_bits = ~cur_word & scan_mask;
  assign free_pos  = bia_pkg::lowest_set(free_bits);
  assign alloc_idx = {scan_word, free_pos};

  // Single-bit operations
  assign in_range  = ({1'b0, idx_q} < cap);
  assign idx_bit   = {{(bia_pkg::WORD_BITS-1){1'b0}}, 1'b1} << idx_q[bia_pkg::BIT_W-1:0];
  assign single_wr = in_range && (cmd_q == bia_pkg::CMD_RELEASE || cmd_q == bia_pkg::CMD_SET ||
                                  cmd_q == bia_pkg::CMD_CLEAR);
  assign single_word = (cmd_q == bia_pkg::CMD_SET) ? (cur_word | idx_bit) : (cur_word & ~idx_bit);

  // Status to the controller
  assign sts.is_alloc  = (cmd_q == bia_pkg::CMD_ALLOC);
  assign sts.is_single = (cmd_q == bia_pkg::CMD_RELEASE) || (cmd_q == bia_pkg::CMD_SET) ||
                         (cmd_q == bia_pkg::CMD_CLEAR) || (cmd_q == bia_pkg::CMD_TEST);
  assign sts.no_words  = (cap_words == '0);
  assign sts.hit       = |free_bits;
  assign sts.last_step = (step_cnt == cap_words);

  // Memory port selection
  assign rd_en   = ctl.rd_start || ctl.rd_next;
  assign rd_addr = ctl.rd_next ? next_word :
                   ((cmd_q == bia_pkg::CMD_ALLOC) ? scan_word : idx_q[bia_pkg::IDX_W-1:bia_pkg::BIT_W]);
  assign wr_en   = ctl.commit_alloc || (ctl.commit_single && single_wr);
  assign wr_addr = ctl.commit_alloc ? scan_word : idx_q[bia_pkg::IDX_W-1:bia_pkg::BIT_W];
  assign wr_data = ctl.commit_alloc ? (cur_word | (32'd1 << free_pos)) : single_word;

  // Word count from a capacity write, rounded up; saturated to MAP_WORDS when registered
  assign cfg_words = 7'(({1'b0, cfg_data} + 12'd31) >> bia_pkg::BIT_W);

  // Memory array, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  // Valid bits and read-valid flag
  always_ff @(posedge clk) begin
    if (rst || cfg_write) begin
      word_valid <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (wr_en) begin
        word_valid[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid_q <= word_valid[rd_addr];
      end
    end
  end

  // Capacity and hint
  always_ff @(posedge clk) begin
    if (rst) begin
      cap_words <= 6'd32;
      hint      <= '0;
    end else if (cfg_write) begin
      cap_words <= (cfg_words > 7'd32) ? 6'd32 : cfg_words[bia_pkg::WCNT_W-1:0];
      hint      <= '0;
    end else if (ctl.commit_alloc) begin
      hint <= {1'b0, alloc_idx} + 11'd1;
    end else if (ctl.commit_single && in_range && cmd_q == bia_pkg::CMD_RELEASE &&
                 ({1'b0, idx_q} < hint)) begin
      hint <= {1'b0, idx_q};
    end
  end

  // Item latch and scan pointer
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_q     <= cmd;
      idx_q     <= entry_index;
      scan_word <= scan_start[bia_pkg::IDX_W-1:bia_pkg::BIT_W];
      start_off <= scan_start[bia_pkg::BIT_W-1:0];
      step_cnt  <= '0;
    end else if (ctl.rd_next) begin
      scan_word <= next_word;
      step_cnt  <= step_cnt + 6'd1;
    end
  end

  // Result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl.commit_alloc || ctl.commit_single || ctl.report_full || ctl.report_plain;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.commit_alloc) begin
      status        <= bia_pkg::ST_OK;
      granted_index <= alloc_idx;
      bit_value     <= 1'b0;
    end else if (ctl.commit_single) begin
      status        <= in_range ? bia_pkg::ST_OK : bia_pkg::ST_RANGE;
      granted_index <= '0;
      bit_value     <= in_range && (cmd_q == bia_pkg::CMD_TEST) && |(cur_word & idx_bit);
    end else if (ctl.report_full) begin
      status        <= bia_pkg::ST_FULL;
      granted_index <= '0;
      bit_value     <= 1'b0;
    end else if (ctl.report_plain) begin
      status        <= bia_pkg::ST_OK;
      granted_index <= '0;
      bit_value     <= 1'b0;
    end
  end

endmodule

// ===== design/bitmap_id_allocator_core.sv =====
// Top level of the bitmap ID allocator: controller plus datapath.
// Depends on bia_pkg, bia_ctrl and bia_datapath.

// Next-fit entry allocator over a 1024-entry used bitmap held as 32 words of
// 32 bits. An item is taken when start is high and busy is low. Its single
// result appears on status, granted_index and bit_value for exactly one cycle
// with done high, and cannot be held off by the receiver. Release, set, clear
// and test read the addressed word in S_FETCH and give their result from
// S_SINGLE. Unknown commands, and an allocate at zero capacity, give it
// straight from S_FETCH. Allocate reads one bitmap word per cycle from the
// scan start, as the bitmap memory has a single read port, and ends at the
// first word with a free entry. With no free entry it visits every word, and
// the start word a second time for the bits below the hint, before full is
// reported. busy drops in the cycle done is shown, so the next item may be
// started then. Writing cfg_data with cfg_write (only while idle) sets the
// capacity, clears the map and zeroes the hint.
module bitmap_id_allocator_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [bia_pkg::CMD_W-1:0]      cmd,
  input  logic [bia_pkg::IDX_W-1:0]      entry_index,
  input  logic                           cfg_write,
  input  logic [bia_pkg::CAP_W-1:0]      cfg_data,
  output logic                           done,
  output logic [bia_pkg::STATUS_W-1:0]   status,
  output logic [bia_pkg::IDX_W-1:0]      granted_index,
  output logic                           bit_value
);

  bia_pkg::ctl_t ctl;
  bia_pkg::sts_t sts;

  // Sequencer
  bia_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .ctl   (ctl),
    .busy  (busy)
  );

  // Bitmap, hint and result registers
  bia_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .ctl           (ctl),
    .sts           (sts),
    .cmd           (cmd),
    .entry_index   (entry_index),
    .cfg_write     (cfg_write),
    .cfg_data      (cfg_data),
    .done          (done),
    .status        (status),
    .granted_index (granted_index),
    .bit_value     (bit_value)
  );

  // An accepted item keeps the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy not raised after item accepted");

  // Results never come in back-to-back cycles
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done high two cycles in a row");

  // A nonzero granted index only comes with a successful allocate
  a_grant_ok: assert property (@(posedge clk) disable iff (rst)
    (done && granted_index != '0) |-> (status == bia_pkg::ST_OK && !bit_value))
    else $error("granted index with non-ok status or bit value");

  // A set bit value only comes with an ok test result
  a_bit_ok: assert property (@(posedge clk) disable iff (rst)
    (done && bit_value) |-> (status == bia_pkg::ST_OK && granted_index == '0))
    else $error("bit value with bad status or granted index");

endmodule
